FILE: rtl/rspe_pkg.sv
package rspe_pkg;

  localparam int BYTE_W = 8;
  localparam int EC_W = 6;
  localparam logic [EC_W-1:0] EC_RESET = 6'd10;
  // low byte of the field polynomial 0x11D
  localparam logic [BYTE_W-1:0] GF_POLY_LO = 8'h1D;
  localparam logic [BYTE_W-1:0] GF_HIGH_BIT = 8'h80;
  localparam logic [BYTE_W-1:0] GF_ONE = 8'h01;

  typedef struct packed {
    logic clr;    // clear remainder and generator
    logic step;   // absorb one message byte
    logic last;   // byte is the final one: load parity, clear remainder
    logic build;  // one generator build step
    logic shift;  // move parity one cell toward the output
  } rspe_cell_ctrl_t;

  function automatic logic [BYTE_W-1:0] gf_xtime(input logic [BYTE_W-1:0] x);
    logic [BYTE_W-1:0] sh;
    sh = {x[BYTE_W-2:0], 1'b0};
    if ((x & GF_HIGH_BIT) != '0) begin
      return sh ^ GF_POLY_LO;
    end
    return sh;
  endfunction

  function automatic logic [BYTE_W-1:0] gf_mul(input logic [BYTE_W-1:0] a,
                                               input logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] x;
    logic [BYTE_W-1:0] acc;
    x = a;
    acc = '0;
    for (int n = 0; n < BYTE_W; n++) begin
      if (b[n]) begin
        acc = acc ^ x;
      end
      x = gf_xtime(x);
    end
    return acc;
  endfunction

endpackage

FILE: rtl/rspe_if.sv
interface rspe_data_if import rspe_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              data_last;

  modport source (output valid, output data_byte, output data_last, input ready);
  modport sink (input valid, input data_byte, input data_last, output ready);
endinterface

interface rspe_parity_if import rspe_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] parity_byte;
  logic              parity_last;

  modport source (output valid, output parity_byte, output parity_last, input ready);
  modport sink (input valid, input parity_byte, input parity_last, output ready);
endinterface

FILE: rtl/rspe_cell.sv
module rspe_cell import rspe_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rspe_cell_ctrl_t   ctrl_i,
  input  logic [BYTE_W-1:0] fb_i,
  input  logic [BYTE_W-1:0] root_i,
  input  logic [BYTE_W-1:0] rem_up_i,
  input  logic [BYTE_W-1:0] gen_lo_i,
  input  logic [BYTE_W-1:0] par_up_i,
  output logic [BYTE_W-1:0] rem_o,
  output logic [BYTE_W-1:0] gen_o,
  output logic [BYTE_W-1:0] par_o
);

  logic [BYTE_W-1:0] rem_q, rem_d;
  logic [BYTE_W-1:0] gen_q, gen_d;
  logic [BYTE_W-1:0] par_q, par_d;
  logic [BYTE_W-1:0] mul_a, mul_b, prod, rem_nxt;

  // one multiplier: feedback times own coefficient, or root times lower neighbor
  assign mul_a   = ctrl_i.build ? root_i : fb_i;
  assign mul_b   = ctrl_i.build ? gen_lo_i : gen_q;
  assign prod    = gf_mul(mul_a, mul_b);
  assign rem_nxt = rem_up_i ^ prod;

  always_comb begin
    rem_d = rem_q;
    gen_d = gen_q;
    par_d = par_q;
    if (ctrl_i.clr) begin
      rem_d = '0;
      gen_d = '0;
    end else if (ctrl_i.build) begin
      gen_d = gen_q ^ prod;
    end else if (ctrl_i.step) begin
      rem_d = ctrl_i.last ? '0 : rem_nxt;
    end
    if (ctrl_i.step && ctrl_i.last && !ctrl_i.clr) begin
      par_d = rem_nxt;
    end else if (ctrl_i.shift) begin
      par_d = par_up_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
      gen_q <= '0;
    end else begin
      rem_q <= rem_d;
      gen_q <= gen_d;
    end
  end

  always_ff @(posedge clk_i) begin
    par_q <= par_d;
  end

  assign rem_o = rem_q;
  assign gen_o = gen_q;
  assign par_o = par_q;

endmodule

FILE: rtl/reed_solomon_parity_encoder_unit.sv
// one message byte per cycle when not held off; a last byte's parity appears in the cycle after it is taken
// and leaves at one byte per cycle while the receiver is ready, clamped parity count bytes, highest order first
// a last byte is held off until the previous parity run has fully drained
// after reset and after every ec_count write the input is held off
// while the cell row builds the generator, one root factor per cycle
// rst_ni is asynchronous, active low; it clears the remainder and sets ec_count to 10
module reed_solomon_parity_encoder_unit import rspe_pkg::*; #(
  parameter int MAX_EC = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [EC_W-1:0]  cfg_wdata_i,
  rspe_data_if.sink        data_i,
  rspe_parity_if.source    parity_o
);

  localparam int EW = $clog2(MAX_EC + 1);

  logic [EC_W-1:0]   ec_q;
  logic              start_q;
  logic [EW-1:0]     bld_cnt_q, bld_cnt_d;
  logic [EW-1:0]     out_cnt_q, out_cnt_d;
  logic [BYTE_W-1:0] root_q, root_d;
  logic [EW-1:0]     eff_ec;
  logic              building;
  logic              in_req, out_req;
  logic [BYTE_W-1:0] fb;
  rspe_cell_ctrl_t   ctrl;

  logic [BYTE_W-1:0] rem_w [MAX_EC];
  logic [BYTE_W-1:0] gen_w [MAX_EC];
  logic [BYTE_W-1:0] par_w [MAX_EC];

  // parity count clamped to 1 .. MAX_EC
  always_comb begin
    if (ec_q == '0) begin
      eff_ec = EW'(1);
    end else if (int'(ec_q) > MAX_EC) begin
      eff_ec = EW'(MAX_EC);
    end else begin
      eff_ec = EW'(ec_q);
    end
  end

  assign building = start_q || (bld_cnt_q != '0);

  assign data_i.ready = !building && !cfg_we_i &&
                        (!data_i.data_last || (out_cnt_q == '0));
  assign in_req  = data_i.valid && data_i.ready;
  assign out_req = parity_o.valid && parity_o.ready;

  assign fb = data_i.data_byte ^ rem_w[0];

  always_comb begin
    ctrl.clr   = cfg_we_i;
    ctrl.step  = in_req;
    ctrl.last  = data_i.data_last;
    ctrl.build = !start_q && (bld_cnt_q != '0) && !cfg_we_i;
    ctrl.shift = out_req;
  end

  always_comb begin
    bld_cnt_d = bld_cnt_q;
    root_d    = root_q;
    out_cnt_d = out_cnt_q;
    if (cfg_we_i) begin
      bld_cnt_d = '0;
      root_d    = GF_ONE;
      out_cnt_d = '0;
    end else begin
      if (start_q) begin
        bld_cnt_d = eff_ec;
      end else if (ctrl.build) begin
        bld_cnt_d = bld_cnt_q - EW'(1);
        root_d    = gf_xtime(root_q);
      end
      if (in_req && data_i.data_last) begin
        out_cnt_d = eff_ec;
      end else if (out_req) begin
        out_cnt_d = out_cnt_q - EW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ec_q      <= EC_RESET;
      start_q   <= 1'b1;
      bld_cnt_q <= '0;
      out_cnt_q <= '0;
      root_q    <= GF_ONE;
    end else begin
      if (cfg_we_i) begin
        ec_q <= cfg_wdata_i;
      end
      start_q   <= cfg_we_i;
      bld_cnt_q <= bld_cnt_d;
      out_cnt_q <= out_cnt_d;
      root_q    <= root_d;
    end
  end

  for (genvar j = 0; j < MAX_EC; j++) begin : g_cell
    logic [BYTE_W-1:0] rem_up, gen_lo, par_up;
    if (j == MAX_EC - 1) begin : g_top
      assign rem_up = '0;
      assign par_up = '0;
    end else begin : g_mid
      assign rem_up = rem_w[j+1];
      assign par_up = par_w[j+1];
    end
    // the monic leading coefficient sits below cell 0
    if (j == 0) begin : g_low
      assign gen_lo = GF_ONE;
    end else begin : g_up
      assign gen_lo = gen_w[j-1];
    end

    rspe_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (ctrl),
      .fb_i     (fb),
      .root_i   (root_q),
      .rem_up_i (rem_up),
      .gen_lo_i (gen_lo),
      .par_up_i (par_up),
      .rem_o    (rem_w[j]),
      .gen_o    (gen_w[j]),
      .par_o    (par_w[j])
    );
  end

  assign parity_o.valid       = (out_cnt_q != '0);
  assign parity_o.parity_byte = par_w[0];
  assign parity_o.parity_last = (out_cnt_q == EW'(1));

endmodule

FILE: rtl/rspe_checker.sv
module rspe_checker import rspe_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              cfg_we_i,
  input logic              in_valid_i,
  input logic              in_ready_i,
  input logic              in_last_i,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input logic [BYTE_W-1:0] out_byte_i,
  input logic              out_last_i
);

  logic in_req, out_req;
  assign in_req  = in_valid_i && in_ready_i;
  assign out_req = out_valid_i && out_ready_i;

  // stalled parity request holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i && !cfg_we_i |=> out_valid_i && $stable(out_byte_i))
    else $error("stalled parity request changed");

  // a register write starts a generator build and drops pending parity
  a_cfg_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> !in_ready_i && !out_valid_i)
    else $error("block not busy after configuration write");

  // the final parity byte ends the run
  a_run_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_req && out_last_i |=> !out_valid_i)
    else $error("parity still valid after final byte");

  // parity only follows a last message byte
  a_run_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_req && in_last_i))
    else $error("parity run without a last message byte");

endmodule

bind reed_solomon_parity_encoder_unit rspe_checker u_rspe_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .cfg_we_i    (cfg_we_i),
  .in_valid_i  (data_i.valid),
  .in_ready_i  (data_i.ready),
  .in_last_i   (data_i.data_last),
  .out_valid_i (parity_o.valid),
  .out_ready_i (parity_o.ready),
  .out_byte_i  (parity_o.parity_byte),
  .out_last_i  (parity_o.parity_last)
);

FILE: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import rspe_pkg::*;

  localparam int EC_MAX = 32;
  localparam int GAP_MAX = 18;
  localparam int SETTLE_CYCLES = 4;
  localparam int TAIL_CYCLES = 40;
  localparam int RANDOM_END = 250;
  localparam longint CYCLE_LIMIT = 1000000;
  localparam logic [BYTE_W:0] FIELD_POLY = 9'h11D;
  localparam int FIELD_ORDER = 255;

  typedef struct packed {
    logic [BYTE_W-1:0] parity_byte;
    logic              parity_last;
  } parity_t;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            cfg_we_i = 1'b0;
  logic [EC_W-1:0] cfg_wdata_i = '0;

  rspe_data_if   data_if ();
  rspe_parity_if parity_if ();

  reed_solomon_parity_encoder_unit #(
    .MAX_EC(EC_MAX)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .data_i     (data_if),
    .parity_o   (parity_if)
  );

  // powers and logs of alpha = 2
  logic [BYTE_W-1:0] alpha_pow [FIELD_ORDER];
  int unsigned       alpha_log [256];

  logic [EC_W-1:0]   ec_reg;
  logic [BYTE_W-1:0] rem_reg [EC_MAX];
  logic [BYTE_W-1:0] gen_coef [EC_MAX];
  parity_t           pending_parity_q [$];
  parity_t           parity_want;

  int     mismatch_count = 0;
  int     sent_count = 0;
  int     stall_left = 0;
  longint cycle_count = 0;
  bit     idle_on = 1'b1;

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Simulation FAILED");
    $finish;
  end

  function automatic void fill_field_tables();
    logic [BYTE_W:0] v;
    v = 9'd1;
    for (int i = 0; i < FIELD_ORDER; i++) begin
      alpha_pow[i] = v[BYTE_W-1:0];
      alpha_log[v[BYTE_W-1:0]] = i;
      v = v << 1;
      if (v[BYTE_W]) begin
        v = v ^ FIELD_POLY;
      end
    end
  endfunction

  function automatic logic [BYTE_W-1:0] gf_product(input logic [BYTE_W-1:0] a,
                                                   input logic [BYTE_W-1:0] b);
    // zero has no log, so a zero factor gives zero
    if (a == '0 || b == '0) begin
      return '0;
    end
    return alpha_pow[(alpha_log[a] + alpha_log[b]) % FIELD_ORDER];
  endfunction

  function automatic int parity_span();
    if (ec_reg == '0) begin
      return 1;
    end
    if (ec_reg > EC_MAX) begin
      return EC_MAX;
    end
    return int'(ec_reg);
  endfunction

  function automatic void derive_generator();
    logic [BYTE_W-1:0] poly [EC_MAX+1];
    int n;
    n = parity_span();
    foreach (poly[i]) begin
      poly[i] = '0;
    end
    poly[0] = 8'h01;
    // multiply in (x + alpha^d), top coefficient stays 1
    for (int d = 0; d < n; d++) begin
      for (int i = d + 1; i >= 1; i--) begin
        poly[i] = poly[i] ^ gf_product(alpha_pow[d], poly[i-1]);
      end
    end
    for (int i = 0; i < EC_MAX; i++) begin
      gen_coef[i] = (i < n) ? poly[i+1] : '0;
    end
  endfunction

  function automatic void load_setting(input logic [EC_W-1:0] v);
    ec_reg = v;
    foreach (rem_reg[i]) begin
      rem_reg[i] = '0;
    end
    derive_generator();
  endfunction

  function automatic void encode_byte(input logic [BYTE_W-1:0] b, input logic last);
    logic [BYTE_W-1:0] fb;
    parity_t p;
    int n;
    n = parity_span();
    fb = b ^ rem_reg[0];
    for (int j = 0; j + 1 < n; j++) begin
      rem_reg[j] = rem_reg[j+1] ^ gf_product(fb, gen_coef[j]);
    end
    rem_reg[n-1] = gf_product(fb, gen_coef[n-1]);
    if (last) begin
      for (int j = 0; j < n; j++) begin
        p.parity_byte = rem_reg[j];
        p.parity_last = (j == n - 1);
        pending_parity_q.push_back(p);
      end
      foreach (rem_reg[i]) begin
        rem_reg[i] = '0;
      end
    end
  endfunction

  function automatic logic [EC_W-1:0] pick_parity_count();
    case ($urandom_range(0, 9))
      0: return 6'd1;
      1: return 6'd32;
      2: return 6'd0;
      3: return EC_W'($urandom_range(33, 63));
      default: return EC_W'($urandom_range(1, 32));
    endcase
  endfunction

  // receiver stalls in bursts
  initial begin
    parity_if.ready <= 1'b0;
    forever begin
      @(negedge clk_i);
      if (!idle_on) begin
        stall_left = 0;
      end else if (stall_left == 0 && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, GAP_MAX);
      end
      if (stall_left > 0) begin
        parity_if.ready <= 1'b0;
        stall_left--;
      end else begin
        parity_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && parity_if.valid && parity_if.ready) begin
      if (pending_parity_q.size() == 0) begin
        $error("parity_byte: expected none, actual %02h", parity_if.parity_byte);
        mismatch_count++;
      end else begin
        parity_want = pending_parity_q.pop_front();
        if (parity_if.parity_byte !== parity_want.parity_byte) begin
          $error("parity_byte: expected %02h, actual %02h",
                 parity_want.parity_byte, parity_if.parity_byte);
          mismatch_count++;
        end
        if (parity_if.parity_last !== parity_want.parity_last) begin
          $error("parity_last: expected %0b, actual %0b",
                 parity_want.parity_last, parity_if.parity_last);
          mismatch_count++;
        end
      end
    end
  end

  // valid is left high after a request, so back-to-back bytes keep it high without a gap
  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic last);
    int gap;
    gap = (idle_on && $urandom_range(0, 5) == 0) ? $urandom_range(1, GAP_MAX) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      data_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    data_if.valid <= 1'b1;
    data_if.data_byte <= b;
    data_if.data_last <= last;
    do @(posedge clk_i); while (!data_if.ready);
    encode_byte(b, last);
    sent_count++;
  endtask

  task automatic send_message(input int len);
    for (int i = 0; i < len; i++) begin
      send_byte(BYTE_W'($urandom_range(0, 255)), i == len - 1);
    end
  endtask

  task automatic quiesce();
    @(negedge clk_i);
    data_if.valid <= 1'b0;
    while (pending_parity_q.size() != 0) begin
      @(negedge clk_i);
    end
    // a byte with no parity may still be in flight
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_parity_count(input logic [EC_W-1:0] v);
    quiesce();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    load_setting(v);
  endtask

  task automatic test_reset_setting();
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h01, 1'b1);
    // second byte cancels the feedback to zero mid-message
    send_byte(8'h53, 1'b0);
    send_byte(rem_reg[0], 1'b0);
    send_byte(8'hA5, 1'b1);
  endtask

  task automatic test_count_extremes();
    logic [EC_W-1:0] counts [5];
    counts = '{6'd1, 6'd32, 6'd0, 6'd63, 6'd33};
    foreach (counts[i]) begin
      write_parity_count(counts[i]);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h00, 1'b1);
    end
  endtask

  task automatic test_abandoned_message();
    send_byte(8'h3C, 1'b0);
    send_byte(8'hC3, 1'b0);
    send_byte(8'h5A, 1'b0);
    write_parity_count(6'd5);
    send_byte(8'h12, 1'b0);
    send_byte(8'hED, 1'b1);
  endtask

  task automatic test_random_messages();
    int len;
    while (sent_count < RANDOM_END) begin
      if ($urandom_range(0, 5) == 0) begin
        write_parity_count(pick_parity_count());
      end
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
      if ($urandom_range(0, 9) == 0) begin
        // broken message, cut short by a rewrite
        repeat (len) send_byte(BYTE_W'($urandom_range(0, 255)), 1'b0);
        write_parity_count(pick_parity_count());
      end else begin
        send_message(len);
      end
    end
  endtask

  task automatic test_back_to_back();
    idle_on = 1'b0;
    write_parity_count(EC_W'($urandom_range(1, 32)));
    repeat (6) send_message(1);
    repeat (6) send_message($urandom_range(2, 5));
  endtask

  initial begin
    data_if.valid <= 1'b0;
    data_if.data_byte <= '0;
    data_if.data_last <= 1'b0;
    fill_field_tables();
    load_setting(EC_RESET);
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_setting();
    test_count_extremes();
    test_abandoned_message();
    test_random_messages();
    test_back_to_back();

    quiesce();
    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
